// ----- rtl/grf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian row filter package
// Widths, weight register constants and shared types of the row filter.
// ----------------------------------------------------------------------------
package grf_pkg;

  // Pixel and weight formats.
  localparam int PIX_W       = 8;
  localparam int WEIGHT_W    = 11;
  localparam int FRAC_BITS   = 10;
  localparam int PROD_W      = PIX_W + WEIGHT_W - FRAC_BITS;

  // Weight register file: one register per tap distance from the centre.
  localparam int WEIGHT_REGS = 7;
  localparam int CFG_IDX_W   = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LAST = 3'd6;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET [WEIGHT_REGS] = '{
    11'd136, 11'd128, 11'd109, 11'd82, 11'd55, 11'd33, 11'd18
  };

  // Front sequencer states.
  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_FLUSH = 2'b10
  } grf_state_e;

endpackage

// ----- rtl/grf_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row filter input channel
// Valid/ready channel carrying one raster pixel and its end-of-image mark.
// ----------------------------------------------------------------------------
interface grf_in_if import grf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             end_of_image;

  modport source (output valid, output pixel_in, output end_of_image, input ready);
  modport sink   (input valid, input pixel_in, input end_of_image, output ready);
endinterface

// ----- rtl/grf_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row filter output channel
// Valid/ready channel carrying one filtered pixel and its last-of-image mark.
// ----------------------------------------------------------------------------
interface grf_out_if import grf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             last_out;

  modport source (output valid, output pixel_out, output last_out, input ready);
  modport sink   (input valid, input pixel_out, input last_out, output ready);
endinterface

// ----- rtl/gaussian_row_fir_13tap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian row filter, 13 taps
// Symmetric Gaussian FIR over a raster pixel stream with programmable
// Q1.10 weights and an end-of-image flush.
// ----------------------------------------------------------------------------
// While an image streams in, the filter takes one pixel per clock and gives
// one filtered pixel per clock once TAP_COUNT pixels have arrived, while
// the queue has room; a job passes from the queue to the product stage and
// then the sum stage, which offers the result. The pixel marked end of image
// is followed by one flush job per position still held in the window, up
// to TAP_COUNT-1 jobs, during which the input is held off: the front-end
// sequencer issues one filter job per cycle while the queue has room. The
// final flushed result carries last_out. Weights are to be written through
// the configuration port while the block is idle, which it does not enforce.
module gaussian_row_fir_13tap import grf_pkg::*; #(
  parameter int TAP_COUNT   = 13,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WEIGHT_W-1:0]  cfg_wdata_i,
  grf_in_if.sink               in_i,
  grf_out_if.source            out_o
);

  localparam int JOB_W = TAP_COUNT * PIX_W + 1;

  logic             fj_valid, fj_ready;
  logic [JOB_W-1:0] fj_data;
  logic             bj_valid, bj_ready;
  logic [JOB_W-1:0] bj_data;

  // Window keeper and job issue.
  grf_front #(
    .TAP_COUNT (TAP_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_data_o  (fj_data)
  );

  // Decoupling queue between front and back.
  grf_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fj_valid),
    .push_ready_o (fj_ready),
    .push_data_i  (fj_data),
    .pop_valid_o  (bj_valid),
    .pop_ready_i  (bj_ready),
    .pop_data_o   (bj_data)
  );

  // Weighted sum and output register.
  grf_back #(
    .TAP_COUNT (TAP_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .job_valid_i (bj_valid),
    .job_ready_o (bj_ready),
    .job_data_i  (bj_data),
    .out_o       (out_o)
  );

endmodule

// ----- rtl/grf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row filter front end
// Accepts pixels, keeps the window of positions still lacking a result and
// issues one filter job per result, including the end-of-image flush.
// ----------------------------------------------------------------------------
module grf_front import grf_pkg::*; #(
  parameter int TAP_COUNT = 13
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  grf_in_if.sink                         in_i,
  output logic                           job_valid_o,
  input  logic                           job_ready_i,
  output logic [TAP_COUNT*PIX_W:0]       job_data_o
);

  localparam int WIN_N = TAP_COUNT - 1;
  localparam int CNT_W = $clog2(TAP_COUNT);

  grf_state_e                     st_q, st_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [WIN_N-1:0][PIX_W-1:0]    win_q, win_d;
  logic [TAP_COUNT-1:0][PIX_W-1:0] job_pix;
  logic                           job_last;
  logic                           accept;
  logic                           full;

  // Input is taken only while streaming and while the queue has room.
  assign in_i.ready = (st_q == ST_RUN) && job_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (cnt_q == CNT_W'(WIN_N));

  // Window update and job issue. Entries past the fill count stay zero, so a
  // flush job reads zeros for pixels beyond the end of the image.
  always_comb begin
    st_d     = st_q;
    cnt_d    = cnt_q;
    win_d    = win_q;
    job_pix  = '0;
    job_last = 1'b0;
    job_valid_o = 1'b0;
    unique case (st_q)
      ST_RUN: begin
        if (accept) begin
          if (full) begin
            job_valid_o = 1'b1;
            for (int k = 0; k < WIN_N; k++) begin
              job_pix[k] = win_q[k];
            end
            job_pix[TAP_COUNT-1] = in_i.pixel_in;
            for (int k = 0; k < WIN_N - 1; k++) begin
              win_d[k] = win_q[k+1];
            end
            win_d[WIN_N-1] = in_i.pixel_in;
          end else begin
            for (int k = 0; k < WIN_N; k++) begin
              if (cnt_q == CNT_W'(k)) begin
                win_d[k] = in_i.pixel_in;
              end
            end
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (in_i.end_of_image) begin
            st_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        job_valid_o = 1'b1;
        for (int k = 0; k < WIN_N; k++) begin
          job_pix[k] = win_q[k];
        end
        job_last = (cnt_q == CNT_W'(1));
        if (job_ready_i) begin
          for (int k = 0; k < WIN_N - 1; k++) begin
            win_d[k] = win_q[k+1];
          end
          win_d[WIN_N-1] = '0;
          cnt_d = cnt_q - CNT_W'(1);
          if (job_last) begin
            st_d = ST_RUN;
          end
        end
      end
      default: begin
        st_d = ST_RUN;
      end
    endcase
  end

  assign job_data_o = {job_last, job_pix};

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_RUN;
      cnt_q <= '0;
      win_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      win_q <= win_d;
    end
  end

endmodule

// ----- rtl/grf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row filter job queue
// Small first-in first-out buffer that decouples the front end from the
// arithmetic back end.
// ----------------------------------------------------------------------------
module grf_queue #(
  parameter int WIDTH = 105,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/grf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row filter back end
// Holds the weight registers and runs each job through a product stage and
// a wrapping sum stage that also serves as the output register.
// ----------------------------------------------------------------------------
module grf_back import grf_pkg::*; #(
  parameter int TAP_COUNT = 13
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [WEIGHT_W-1:0]      cfg_wdata_i,
  input  logic                     job_valid_i,
  output logic                     job_ready_o,
  input  logic [TAP_COUNT*PIX_W:0] job_data_i,
  grf_out_if.source                out_o
);

  localparam int CENTER = (TAP_COUNT - 1) / 2;

  logic [WEIGHT_W-1:0]               weight_q [WEIGHT_REGS];
  logic [TAP_COUNT-1:0][WEIGHT_W-1:0] tap_w;
  logic [TAP_COUNT-1:0][PIX_W-1:0]   job_pix;
  logic                              job_last;
  logic [TAP_COUNT-1:0][PROD_W-1:0]  prod_q;
  logic                              prod_valid_q;
  logic                              prod_last_q;
  logic                              out_valid_q;
  logic [PIX_W-1:0]                  out_pix_q, sum_d;
  logic                              out_last_q;
  logic                              adv_out, adv_prod;

  // Weight registers; writes beyond the last register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WEIGHT_REGS; i++) begin
        weight_q[i] <= WEIGHT_RESET[i];
      end
    end else if (cfg_we_i && (cfg_idx_i <= REG_WEIGHT_LAST)) begin
      weight_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Each tap takes the weight for its distance from the centre; taps further
  // out than the register file reaches get weight zero.
  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
    localparam int DIST = (k >= CENTER) ? (k - CENTER) : (CENTER - k);
    if (DIST < WEIGHT_REGS) begin : g_w
      assign tap_w[k] = weight_q[DIST];
    end else begin : g_zero
      assign tap_w[k] = '0;
    end
  end

  assign job_pix  = job_data_i[TAP_COUNT*PIX_W-1:0];
  assign job_last = job_data_i[TAP_COUNT*PIX_W];

  // Stage advance: the output stage moves when empty or taken, the product
  // stage when empty or when the output stage moves.
  assign adv_out     = !out_valid_q || out_o.ready;
  assign adv_prod    = !prod_valid_q || adv_out;
  assign job_ready_o = adv_prod;

  // Product stage: one multiplier per tap, each product truncated on its own.
  // Both factors are widened to the full product width before multiplying.
  always_ff @(posedge clk_i) begin
    if (adv_prod && job_valid_i) begin
      for (int k = 0; k < TAP_COUNT; k++) begin
        prod_q[k] <= PROD_W'(({{WEIGHT_W{1'b0}}, job_pix[k]} *
                              {{PIX_W{1'b0}}, tap_w[k]}) >> FRAC_BITS);
      end
      prod_last_q <= job_last;
    end
  end

  // Sum of the truncated products, wrapped to a byte.
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < TAP_COUNT; k++) begin
      sum_d = sum_d + prod_q[k][PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && prod_valid_q) begin
      out_pix_q  <= sum_d;
      out_last_q <= prod_last_q;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (adv_prod) begin
        prod_valid_q <= job_valid_i;
      end
      if (adv_out) begin
        out_valid_q <= prod_valid_q;
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pixel_out = out_pix_q;
  assign out_o.last_out  = out_last_q;

endmodule

// ----- rtl/grf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row filter port checker
// Concurrent checks on the filter's channels, bound to the top level.
// ----------------------------------------------------------------------------
module grf_checker import grf_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             in_eoi_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [PIX_W-1:0] out_pixel_i,
  input logic             out_last_i
);

  logic [3:0] eoi_pending_q;
  logic       in_acc, out_last_acc;

  assign in_acc       = in_valid_i && in_ready_i;
  assign out_last_acc = out_valid_i && out_ready_i && out_last_i;

  // Count of images whose closing result has not yet been delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eoi_pending_q <= '0;
    end else if ((in_acc && in_eoi_i) && !out_last_acc) begin
      eoi_pending_q <= eoi_pending_q + 4'd1;
    end else if (out_last_acc && !(in_acc && in_eoi_i)) begin
      eoi_pending_q <= eoi_pending_q - 4'd1;
    end
  end

  // A stalled result stays offered.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_pixel_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  // The flush holds off input in the cycle after an end-of-image item.
  a_flush_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_eoi_i |=> !in_ready_i)
    else $error("input taken straight after end of image");

  // A closing result only follows an accepted end-of-image item.
  a_last_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> eoi_pending_q != 4'd0)
    else $error("last result without end of image");

endmodule

bind gaussian_row_fir_13tap grf_checker u_grf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_eoi_i    (in_i.end_of_image),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_pixel_i (out_o.pixel_out),
  .out_last_i  (out_o.last_out)
);

// ----- tb/gaussian_row_fir_13tap_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian row filter testbench
// Streams directed and random images through the 13-tap row filter under
// several weight settings and handshake patterns. A scoreboard predicts
// every filtered pixel, including the end-of-image flush, and checks each
// output item in order.
// ----------------------------------------------------------------------------

// Predicts the filtered pixels of the stream and checks the outputs in order.
class filter_scoreboard;
  localparam int TAPS   = 13;
  localparam int CENTRE = (TAPS - 1) / 2;

  typedef struct packed {
    logic [grf_pkg::PIX_W-1:0] pixel;
    logic                      last;
  } filtered_t;

  bit [grf_pkg::WEIGHT_W-1:0] weight [grf_pkg::WEIGHT_REGS];
  bit [grf_pkg::PIX_W-1:0]    row [TAPS-1];
  bit [grf_pkg::PIX_W-1:0]    line [TAPS];
  int unsigned                held;
  filtered_t                  pending [$];
  int unsigned                errors;

  function new();
    for (int i = 0; i < grf_pkg::WEIGHT_REGS; i++) weight[i] = grf_pkg::WEIGHT_RESET[i];
    held   = 0;
    errors = 0;
  endfunction

  // Writes to an index past the last weight register are dropped.
  function void set_weight(int unsigned idx, bit [grf_pkg::WEIGHT_W-1:0] value);
    if (idx < grf_pkg::WEIGHT_REGS) weight[idx] = value;
  endfunction

  function void complain(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // Each tap product is shifted on its own; pixels past n count as zero.
  function bit [grf_pkg::PIX_W-1:0] tap_sum(int unsigned start, int unsigned n);
    int unsigned sum;
    int unsigned pos;
    int unsigned tap_dist;
    int unsigned prod;
    sum = 0;
    for (int k = 0; k < TAPS; k++) begin
      pos      = start + k;
      tap_dist = (k >= CENTRE) ? k - CENTRE : CENTRE - k;
      if (pos < n && tap_dist < grf_pkg::WEIGHT_REGS) begin
        prod = line[pos] * weight[tap_dist];
        sum += prod >> grf_pkg::FRAC_BITS;
      end
    end
    return sum[grf_pkg::PIX_W-1:0];
  endfunction

  // Called for every accepted input item.
  function void note_pixel(bit [grf_pkg::PIX_W-1:0] pixel, bit eoi);
    int unsigned n;
    n = held;
    for (int i = 0; i < n; i++) line[i] = row[i];
    line[n] = pixel;
    n++;
    // A full window completes the oldest position.
    if (n >= TAPS) begin
      pending.push_back('{pixel: tap_sum(0, n), last: 1'b0});
      for (int i = 0; i < n - 1; i++) line[i] = line[i + 1];
      n--;
    end
    if (eoi) begin
      // Flush every position still held, oldest first.
      for (int s = 0; s < n; s++) pending.push_back('{pixel: tap_sum(s, n), last: s + 1 == n});
      for (int i = 0; i < TAPS - 1; i++) row[i] = '0;
      held = 0;
    end else begin
      for (int i = 0; i < n; i++) row[i] = line[i];
      held = n;
    end
  endfunction

  // Called for every accepted output item.
  function void check_result(bit [grf_pkg::PIX_W-1:0] pixel, bit last);
    filtered_t want;
    if (pending.size() == 0) begin
      complain($sformatf("unexpected output item: pixel_out %0d last_out %0b", pixel, last));
      return;
    end
    want = pending.pop_front();
    if (pixel !== want.pixel)
      complain($sformatf("pixel_out mismatch: expected %0d, got %0d", want.pixel, pixel));
    if (last !== want.last)
      complain($sformatf("last_out mismatch: expected %0b, got %0b", want.last, last));
  endfunction

  function void report_leftover();
    if (pending.size() != 0)
      complain($sformatf("%0d expected output items never arrived", pending.size()));
  endfunction
endclass

module gaussian_row_fir_13tap_test;
  import grf_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 32;
  localparam int PHASE_ITEMS  = 24;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_WEIGHT_LAST + 1'b1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [WEIGHT_W-1:0]  cfg_wdata;

  grf_in_if  in_if ();
  grf_out_if out_if ();

  gaussian_row_fir_13tap dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  filter_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  bit          hold_ack;
  int unsigned hold_left;
  int unsigned quiet;

  // Clock.
  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // Output side: random stalls, and a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output monitor and watchdog on accepted items.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) sb.check_result(out_if.pixel_out, out_if.last_out);
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Offers one pixel, after a random idle gap, and waits for it to be taken.
  // Entered and left at a falling edge.
  task automatic send_item(input logic [PIX_W-1:0] pixel, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.pixel_in     <= pixel;
    in_if.end_of_image <= eoi;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_pixel(pixel, eoi);
    @(negedge clk_i);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Whole images of random length, each closed by its end-of-image pixel.
  task automatic send_images(input int unsigned target);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        len = $urandom_range(45, 30);
      end else if (pick < 3) begin
        len = $urandom_range(14, 12);
      end else begin
        len = $urandom_range(20, 1);
      end
      for (int i = 0; i < len; i++) send_item(pick_pixel(), i == len - 1);
      sent += len;
    end
  endtask

  // Lets the block go idle: every expected item out, then the pipeline drained.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk_i);
    sb.set_weight(idx, value);
  endtask

  // Weight patterns: 0 all maximum, 1 alternating zero and 1024,
  // 2 random in range, 3 random over the full register width.
  task automatic load_weights(input int unsigned pattern);
    logic [WEIGHT_W-1:0] value;
    for (int i = 0; i < WEIGHT_REGS; i++) begin
      case (pattern)
        0: value = '1;
        1: value = (i % 2 == 0) ? WEIGHT_W'(0) : WEIGHT_W'(1024);
        2: value = WEIGHT_W'($urandom_range(1024));
        default: value = WEIGHT_W'($urandom_range(2047));
      endcase
      write_reg(CFG_IDX_W'(i), value);
    end
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.pixel_in     = '0;
    in_if.end_of_image = 1'b0;
    out_if.ready       = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_req           = 1'b0;
    hold_ack           = 1'b0;
    hold_left          = 0;
    quiet              = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed images at reset weights: a lone pixel, a window exactly full
    // of white, a two-pixel image and a short ramp.
    send_item('1, 1'b1);
    for (int i = 0; i < 13; i++) send_item('1, i == 12);
    send_item('0, 1'b0);
    send_item('1, 1'b1);
    for (int i = 0; i < 8; i++) send_item(PIX_W'(i * 36), i == 7);
    send_images(PHASE_ITEMS / 2);
    settle();

    // All weights at the register maximum, beyond unity; a write to the
    // spare index must leave them alone. Sender mostly idle.
    load_weights(0);
    write_reg(REG_SPARE, '0);
    cfg_we <= 1'b0;
    @(negedge clk_i);
    send_idle_pct = 88;
    send_images(PHASE_ITEMS);
    settle();

    // Alternating zero and unity weights; receiver mostly stalling.
    load_weights(1);
    send_idle_pct  = 0;
    recv_stall_pct = 88;
    send_images(PHASE_ITEMS);
    settle();

    // Random in-range weights; light idling on both sides.
    load_weights(2);
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    send_images(PHASE_ITEMS);
    settle();

    // Random full-width weights at full rate, opening with a long hold-off
    // on the output so that the block backs up onto its input.
    load_weights(3);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = ~hold_req;
    send_images(PHASE_ITEMS);
    settle();

    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
